// ----- rtl/mcpg_pkg.sv -----
// mcpg_pkg: shared constants and types of the midpoint circle point generator
// no dependencies; imported by the interfaces and every module of the block
package mcpg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_BITS    = 6;
  localparam int RADIUS_MAX     = 63;
  localparam int OFF_BITS       = 7;
  localparam int DEC_BITS       = 12;
  localparam int GROUP_CAP      = 48;
  localparam int CNT_BITS       = $clog2(GROUP_CAP + 1);
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS     = $clog2(Q_DEPTH + 1);

  localparam int DEC_INIT      = 3;
  localparam int DEC_STEP_IN   = 6;
  localparam int DEC_STEP_OUT  = 10;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ----- rtl/mcpg_if.sv -----
// mcpg_req_if and mcpg_pts_if: valid/ready channels for requests and point groups
// depends on mcpg_pkg for the default coordinate width and radius width
interface mcpg_req_if
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COORD_BITS-1:0]  centre_x;
  logic [COORD_BITS-1:0]  centre_y;
  logic [RADIUS_BITS-1:0] radius;

  modport source (output valid, centre_x, centre_y, radius, input ready);
  modport sink   (input valid, centre_x, centre_y, radius, output ready);
endinterface

interface mcpg_pts_if
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_plus_a;
  logic [COORD_BITS-1:0] x_minus_a;
  logic [COORD_BITS-1:0] x_plus_b;
  logic [COORD_BITS-1:0] x_minus_b;
  logic [COORD_BITS-1:0] y_plus_a;
  logic [COORD_BITS-1:0] y_minus_a;
  logic [COORD_BITS-1:0] y_plus_b;
  logic [COORD_BITS-1:0] y_minus_b;
  logic                  last_of_circle;

  modport source (output valid, x_plus_a, x_minus_a, x_plus_b, x_minus_b,
                  y_plus_a, y_minus_a, y_plus_b, y_minus_b, last_of_circle,
                  input ready);
  modport sink   (input valid, x_plus_a, x_minus_a, x_plus_b, x_minus_b,
                  y_plus_a, y_minus_a, y_plus_b, y_minus_b, last_of_circle,
                  output ready);
endinterface

// ----- rtl/mcpg_front.sv -----
// mcpg_front: accepts circle requests, clamps the radius and queues them
// depends on mcpg_pkg and mcpg_req_if; feeds mcpg_back
module mcpg_front
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  mcpg_req_if.sink               in_ch,
  output logic                   q_valid,
  output logic [COORD_BITS-1:0]  q_cx,
  output logic [COORD_BITS-1:0]  q_cy,
  output logic [RADIUS_BITS-1:0] q_r,
  input  logic                   q_pop
);

  logic [COORD_BITS-1:0]  cx_r [Q_DEPTH];
  logic [COORD_BITS-1:0]  cy_r [Q_DEPTH];
  logic [RADIUS_BITS-1:0] r_r  [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [RADIUS_BITS-1:0] r_clamped;
  logic                   push, pop;

  // radius saturation
  assign r_clamped = (int'(in_ch.radius) > RADIUS_MAX) ? RADIUS_BITS'(RADIUS_MAX)
                                                       : in_ch.radius;

  assign in_ch.ready = (cnt_r != Q_CNT_BITS'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;

  assign q_cx = cx_r[rd_ptr_r];
  assign q_cy = cy_r[rd_ptr_r];
  assign q_r  = r_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cx_r[wr_ptr_r] <= in_ch.centre_x;
      cy_r[wr_ptr_r] <= in_ch.centre_y;
      r_r[wr_ptr_r]  <= r_clamped;
    end
  end

endmodule

// ----- rtl/mcpg_back.sv -----
// mcpg_back: runs the midpoint circle loop, one point group per step
// depends on mcpg_pkg and mcpg_pts_if; pops requests from mcpg_front
module mcpg_back
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  logic [COORD_BITS-1:0]  q_cx,
  input  logic [COORD_BITS-1:0]  q_cy,
  input  logic [RADIUS_BITS-1:0] q_r,
  output logic                   q_pop,
  mcpg_pts_if.source             out_ch
);

  back_state_t state_r, state_nxt;

  logic [COORD_BITS-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [OFF_BITS:0]   a_r, a_nxt, b_r, b_nxt, a_inc;
  logic signed [DEC_BITS-1:0] d_r, d_nxt, a_ext, b_ext;
  logic [CNT_BITS-1:0]        cnt_r, cnt_nxt, cnt_inc;
  logic [COORD_BITS-1:0]      a_c, b_c;
  logic                       slot_free, last;

  logic                  ov_r, ov_nxt;
  logic [COORD_BITS-1:0] xpa_r, xpa_nxt, xma_r, xma_nxt, xpb_r, xpb_nxt, xmb_r, xmb_nxt;
  logic [COORD_BITS-1:0] ypa_r, ypa_nxt, yma_r, yma_nxt, ypb_r, ypb_nxt, ymb_r, ymb_nxt;
  logic                  lst_r, lst_nxt;

  assign slot_free = !ov_r || out_ch.ready;
  assign a_inc     = a_r + 1'b1;
  assign cnt_inc   = cnt_r + 1'b1;
  assign a_ext     = DEC_BITS'(a_inc);
  assign b_ext     = DEC_BITS'(b_r);
  // offsets are non-negative whenever a group is emitted
  assign a_c = {{(COORD_BITS-OFF_BITS){1'b0}}, a_r[OFF_BITS-1:0]};
  assign b_c = {{(COORD_BITS-OFF_BITS){1'b0}}, b_r[OFF_BITS-1:0]};

  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    last      = 1'b0;
    ov_nxt    = ov_r && !out_ch.ready;
    xpa_nxt   = xpa_r;
    xma_nxt   = xma_r;
    xpb_nxt   = xpb_r;
    xmb_nxt   = xmb_r;
    ypa_nxt   = ypa_r;
    yma_nxt   = yma_r;
    ypb_nxt   = ypb_r;
    ymb_nxt   = ymb_r;
    lst_nxt   = lst_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cx_nxt    = q_cx;
          cy_nxt    = q_cy;
          a_nxt     = '0;
          b_nxt     = (OFF_BITS+1)'(q_r);
          d_nxt     = DEC_BITS'(DEC_INIT) - (DEC_BITS'(q_r) <<< 1);
          cnt_nxt   = '0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (slot_free) begin
          xpa_nxt = cx_r + a_c;
          xma_nxt = cx_r - a_c;
          xpb_nxt = cx_r + b_c;
          xmb_nxt = cx_r - b_c;
          ypa_nxt = cy_r + a_c;
          yma_nxt = cy_r - a_c;
          ypb_nxt = cy_r + b_c;
          ymb_nxt = cy_r - b_c;
          a_nxt   = a_inc;
          if (d_r < 0) begin
            d_nxt = d_r + (a_ext <<< 2) + DEC_BITS'(DEC_STEP_IN);
            b_nxt = b_r;
          end else begin
            d_nxt = d_r + DEC_BITS'(DEC_STEP_OUT) + ((a_ext - b_ext) <<< 2);
            b_nxt = b_r - 1'b1;
          end
          cnt_nxt = cnt_inc;
          last    = (a_inc > b_nxt) || (cnt_inc == CNT_BITS'(GROUP_CAP));
          lst_nxt = last;
          ov_nxt  = 1'b1;
          if (last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
      a_r     <= '0;
      b_r     <= '0;
      d_r     <= '0;
      cnt_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      d_r     <= d_nxt;
      cnt_r   <= cnt_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
    end
  end

  // output payload, no reset
  always_ff @(posedge clk) begin
    xpa_r <= xpa_nxt;
    xma_r <= xma_nxt;
    xpb_r <= xpb_nxt;
    xmb_r <= xmb_nxt;
    ypa_r <= ypa_nxt;
    yma_r <= yma_nxt;
    ypb_r <= ypb_nxt;
    ymb_r <= ymb_nxt;
    lst_r <= lst_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.x_plus_a       = xpa_r;
  assign out_ch.x_minus_a      = xma_r;
  assign out_ch.x_plus_b       = xpb_r;
  assign out_ch.x_minus_b      = xmb_r;
  assign out_ch.y_plus_a       = ypa_r;
  assign out_ch.y_minus_a      = yma_r;
  assign out_ch.y_plus_b       = ypb_r;
  assign out_ch.y_minus_b      = ymb_r;
  assign out_ch.last_of_circle = lst_r;

endmodule

// ----- rtl/midpoint_circle_point_generator_unit.sv -----
// midpoint_circle_point_generator_unit: top level of the circle point generator
// depends on mcpg_pkg, mcpg_if, mcpg_front and mcpg_back
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | centre_x, centre_y, radius
//   out_ch   | out | valid/ready        | eight mirrored coordinates, last_of_circle
//
// a circle of radius r gives about 0.71*r + 1 point groups, at most 48, one per cycle while out_ch is ready
// the loop unit passes through its idle state between circles to load the next request
// the loop unit handles one circle at a time; a two-entry queue holds waiting requests
// synchronous active-low reset empties the queue and the output register
// a stalled output holds the loop in place; requests keep queueing until the queue is full
module midpoint_circle_point_generator_unit
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mcpg_req_if.sink   in_ch,
  mcpg_pts_if.source out_ch
);

  logic                   q_valid;
  logic                   q_pop;
  logic [COORD_BITS-1:0]  q_cx;
  logic [COORD_BITS-1:0]  q_cy;
  logic [RADIUS_BITS-1:0] q_r;

  mcpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cx    (q_cx),
    .q_cy    (q_cy),
    .q_r     (q_r),
    .q_pop   (q_pop)
  );

  mcpg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cx    (q_cx),
    .q_cy    (q_cy),
    .q_r     (q_r),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
